[rtl/core/packed_2bpp_framebuffer_writer_top_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the packed 2bpp frame store writer
// clocked on clk, quiet while rst_n is low unless the macro says otherwise
// ----------------------------------------------------------------------------
`ifndef PACKED_2BPP_FRAMEBUFFER_WRITER_TOP_ASSERT_SVH
`define PACKED_2BPP_FRAMEBUFFER_WRITER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property checked outside reset
`define P2FB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define P2FB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define P2FB_ASSERT(lbl, prop, msg)
`define P2FB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/core/p2fb_pkg.sv]
// ----------------------------------------------------------------------------
// p2fb_pkg
// shared constants, types and the colour quantiser of the 2bpp frame store
// ----------------------------------------------------------------------------
`default_nettype none

package p2fb_pkg;

    // store geometry
    localparam int STORE_BYTES = 131072;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int LEN_W       = ADDR_W + 1;

    // field widths
    localparam int DIM_W   = 11;
    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;
    localparam int IDX_W   = 17;
    localparam int PROD_W  = 2 * DIM_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int POS_W   = SUM_W - 2;
    localparam int RAW_W   = PROD_W - 2;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd800;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

    // opcodes
    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_FILL = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // colour codes
    localparam logic [1:0] COLOR_BLACK  = 2'b00;
    localparam logic [1:0] COLOR_WHITE  = 2'b01;
    localparam logic [1:0] COLOR_YELLOW = 2'b10;
    localparam logic [1:0] COLOR_RED    = 2'b11;
    localparam logic [1:0] PIX_MASK     = 2'b11;

    // quantiser thresholds
    localparam logic [CHAN_W-1:0] THRESH_HI = 8'd200;
    localparam logic [CHAN_W-1:0] THRESH_LO = 8'd50;

    // one request to the store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

    // first match wins
    function automatic logic [1:0] quantize(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        logic [1:0] code;
        priority if (r > THRESH_HI && g > THRESH_HI && b < THRESH_LO)
            code = COLOR_YELLOW;
        else if (r > THRESH_HI && g < THRESH_LO && b < THRESH_LO)
            code = COLOR_RED;
        else if (r < THRESH_LO && g < THRESH_LO && b < THRESH_LO)
            code = COLOR_BLACK;
        else
            code = COLOR_WHITE;
        return code;
    endfunction

endpackage

`default_nettype wire

[rtl/core/packed_2bpp_framebuffer_writer_top.sv]
// ----------------------------------------------------------------------------
// packed_2bpp_framebuffer_writer_top
// frame store of four-colour pixels, four to a byte, leftmost in bits 7..6
//
// a request is taken when start is high and busy is low; opcode picks draw,
// fill or read, and the remaining fields are sampled at that edge only
// every request gives exactly one result: done is high for a single cycle
// with read_byte, clipped and color_code valid alongside it
// draw and read take 3 cycles from the accepting edge to the done edge:
// operand capture with the y*width multiply, address and clip check with
// the store read, then modify/write back or read return
// a dropped draw, the unused opcode and an empty fill end after 2 cycles
// a fill takes 2 + panel length cycles (length capped at the store size),
// one store byte written per cycle through the single write port
// the next request may be taken in the cycle done is shown
// the receiver cannot stall, so results are never held back
// panel_width and panel_height are set through cfg_write/cfg_index/cfg_data
// while idle; reset restores 800 x 480 and returns to idle
// store contents are undefined after reset until written
// ----------------------------------------------------------------------------
`default_nettype none

`include "packed_2bpp_framebuffer_writer_top_assert.svh"

module packed_2bpp_framebuffer_writer_top
    import p2fb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    // request channel
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           opcode,
    input  wire logic [COORD_W-1:0]   pixel_x,
    input  wire logic [COORD_W-1:0]   pixel_y,
    input  wire logic [CHAN_W-1:0]    red,
    input  wire logic [CHAN_W-1:0]    green,
    input  wire logic [CHAN_W-1:0]    blue,
    input  wire logic [IDX_W-1:0]     read_index,
    // result channel
    output logic                      done,
    output logic [7:0]                read_byte,
    output logic                      clipped,
    output logic [1:0]                color_code
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CALC = 3'd1;
    localparam logic [2:0] ST_RMW  = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_FILL = 3'd4;

    // panel size registers
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // control state
    logic [2:0] state_reg, state_next;
    logic       done_reg, done_next;

    // captured request
    logic [1:0]        op_reg;
    logic [DIM_W-1:0]  x_lo_reg;
    logic              clip_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [IDX_W-1:0]  ri_reg;
    logic [1:0]        code_reg;

    // working registers
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    // result registers
    logic [7:0] rbyte_reg, rbyte_next;
    logic       clip_out_reg, clip_out_next;
    logic [1:0] code_out_reg, code_out_next;

    // store interface
    store_req_t st_req;
    logic [7:0] st_rdata;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // ---- configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ---- operand capture: clip test and the one multiply
    logic [DIM_W-1:0] mul_a;
    logic             clip_in;

    // fill multiplies width by height, draw multiplies width by row
    assign mul_a = (opcode == OP_FILL) ? height_reg : pixel_y[DIM_W-1:0];

    // negative coordinates or beyond the panel
    assign clip_in = pixel_x[COORD_W-1] || pixel_y[COORD_W-1] ||
                     (pixel_x[DIM_W-1:0] >= width_reg) ||
                     (pixel_y[DIM_W-1:0] >= height_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            x_lo_reg <= pixel_x[DIM_W-1:0];
            clip_reg <= clip_in;
            prod_reg <= PROD_W'(mul_a) * PROD_W'(width_reg);
            ri_reg   <= read_index;
            code_reg <= quantize(red, green, blue);
        end
    end

    // ---- address and length derivation
    logic [SUM_W-1:0] pix_sum;
    logic [POS_W-1:0] pos;
    logic             pos_oob;
    logic             ri_oob;
    logic [RAW_W-1:0] fill_raw;
    logic [LEN_W-1:0] fill_len;
    logic             fill_last;

    assign pix_sum  = SUM_W'(x_lo_reg) + SUM_W'(prod_reg);
    assign pos      = pix_sum[SUM_W-1:2];
    assign pos_oob  = (32'(pos) >= STORE_BYTES);
    assign ri_oob   = (32'(ri_reg) >= STORE_BYTES);
    assign fill_raw = prod_reg[PROD_W-1:2];
    // fill stops at the end of the store
    assign fill_len = (32'(fill_raw) > STORE_BYTES) ? LEN_W'(STORE_BYTES)
                                                   : LEN_W'(fill_raw);
    assign fill_last = ({1'b0, addr_reg} == (len_reg - LEN_W'(1)));

    // ---- pixel merge into the byte read back
    logic [2:0] pix_shift;
    logic [7:0] merged;

    // leftmost pixel of the group sits in the top two bits
    assign pix_shift = 3'd6 - {x_lo_reg[1:0], 1'b0};
    assign merged    = (st_rdata & ~(8'(PIX_MASK) << pix_shift)) |
                       (8'(code_reg) << pix_shift);

    // ---- sequencer
    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        addr_next     = addr_reg;
        len_next      = len_reg;
        rbyte_next    = rbyte_reg;
        clip_out_next = clip_out_reg;
        code_out_next = code_out_reg;
        st_req        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CALC;
                end
            end

            ST_CALC:
            begin
                unique case (op_reg)
                    OP_DRAW:
                    begin
                        if (clip_reg || pos_oob)
                        begin
                            // dropped draw still reports its colour
                            state_next    = ST_IDLE;
                            done_next     = 1'b1;
                            rbyte_next    = '0;
                            clip_out_next = 1'b1;
                            code_out_next = code_reg;
                        end
                        else
                        begin
                            st_req.re    = 1'b1;
                            st_req.raddr = ADDR_W'(pos);
                            addr_next    = ADDR_W'(pos);
                            state_next   = ST_RMW;
                        end
                    end

                    OP_FILL:
                    begin
                        if (fill_len == '0)
                        begin
                            state_next    = ST_IDLE;
                            done_next     = 1'b1;
                            rbyte_next    = '0;
                            clip_out_next = 1'b0;
                            code_out_next = code_reg;
                        end
                        else
                        begin
                            addr_next  = '0;
                            len_next   = fill_len;
                            state_next = ST_FILL;
                        end
                    end

                    OP_READ:
                    begin
                        if (ri_oob)
                        begin
                            state_next    = ST_IDLE;
                            done_next     = 1'b1;
                            rbyte_next    = '0;
                            clip_out_next = 1'b0;
                            code_out_next = COLOR_BLACK;
                        end
                        else
                        begin
                            st_req.re    = 1'b1;
                            st_req.raddr = ADDR_W'(ri_reg);
                            state_next   = ST_READ;
                        end
                    end

                    default:
                    begin
                        // unused opcode: all-zero result, no store access
                        state_next    = ST_IDLE;
                        done_next     = 1'b1;
                        rbyte_next    = '0;
                        clip_out_next = 1'b0;
                        code_out_next = COLOR_BLACK;
                    end
                endcase
            end

            ST_RMW:
            begin
                st_req.we     = 1'b1;
                st_req.waddr  = addr_reg;
                st_req.wdata  = merged;
                state_next    = ST_IDLE;
                done_next     = 1'b1;
                rbyte_next    = '0;
                clip_out_next = 1'b0;
                code_out_next = code_reg;
            end

            ST_READ:
            begin
                state_next    = ST_IDLE;
                done_next     = 1'b1;
                rbyte_next    = st_rdata;
                clip_out_next = 1'b0;
                code_out_next = COLOR_BLACK;
            end

            ST_FILL:
            begin
                st_req.we    = 1'b1;
                st_req.waddr = addr_reg;
                st_req.wdata = {code_reg, code_reg, code_reg, code_reg};
                if (fill_last)
                begin
                    state_next    = ST_IDLE;
                    done_next     = 1'b1;
                    rbyte_next    = '0;
                    clip_out_next = 1'b0;
                    code_out_next = code_reg;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        rbyte_reg    <= rbyte_next;
        clip_out_reg <= clip_out_next;
        code_out_reg <= code_out_next;
    end

    // ---- frame store
    p2fb_store u_store (
        .clk   (clk),
        .req   (st_req),
        .rdata (st_rdata)
    );

    assign done       = done_reg;
    assign read_byte  = rbyte_reg;
    assign clipped    = clip_out_reg;
    assign color_code = code_out_reg;

    // ---- checks
    `P2FB_ASSERT(a_accept_goes_busy, accept |=> busy, "request accepted but block not busy")
    `P2FB_ASSERT(a_done_only_after_work, done |-> ($past(busy) && !busy), "result without work")
    `P2FB_ASSERT(a_clip_no_byte, (done && clipped) |-> (read_byte == 8'd0), "clipped result carries a byte")
    `P2FB_ASSERT(a_write_in_place, st_req.we |-> (state_reg == ST_RMW || state_reg == ST_FILL), "store written outside write-back or fill")
    `P2FB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!done && !busy), "activity during reset")

endmodule

`default_nettype wire

[rtl/core/p2fb_store.sv]
// ----------------------------------------------------------------------------
// p2fb_store
// frame store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module p2fb_store
    import p2fb_pkg::*;
(
    input  wire logic       clk,
    input  wire store_req_t req,
    output logic [7:0]      rdata
);

    logic [7:0] mem [STORE_BYTES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

`default_nettype wire
